// File: rtl/core/owm_pkg.sv
// Shared types, codes and reset constants of the single-line bus master.
package owm_pkg;

    localparam int CFG_W          = 10;
    localparam int CFG_IDX_W      = 3;
    localparam int TIMER_BITS_DEF = 10;

    localparam logic [CFG_W-1:0] RESET_LOW_DEF     = CFG_W'(480);
    localparam logic [CFG_W-1:0] PRESENCE_WAIT_DEF = CFG_W'(65);
    localparam logic [CFG_W-1:0] RESET_TAIL_DEF    = CFG_W'(400);
    localparam logic [CFG_W-1:0] WRITE_ONE_LOW_DEF = CFG_W'(1);
    localparam logic [CFG_W-1:0] WRITE_ZERO_DEF    = CFG_W'(60);
    localparam logic [CFG_W-1:0] WRITE_SLOT_DEF    = CFG_W'(61);
    localparam logic [CFG_W-1:0] READ_LOW_DEF      = CFG_W'(2);
    localparam logic [CFG_W-1:0] READ_SLOT_DEF     = CFG_W'(82);

    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_ONE_LOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_ZERO    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_SLOT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_READ_LOW      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SLOT     = 3'd7;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_RESET = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [2:0] LAST_BIT = 3'd7;

    typedef struct packed {
        logic [CFG_W-1:0] reset_low_us;
        logic [CFG_W-1:0] presence_wait_us;
        logic [CFG_W-1:0] reset_tail_us;
        logic [CFG_W-1:0] write_one_low_us;
        logic [CFG_W-1:0] write_zero_low_us;
        logic [CFG_W-1:0] write_slot_us;
        logic [CFG_W-1:0] read_low_us;
        logic [CFG_W-1:0] read_slot_us;
    } owm_cfg_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] write_byte;
        logic       line_level;
    } owm_item_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       presence;
    } owm_result_t;

endpackage

// File: rtl/core/owm_cfg_regs.sv
// Timing configuration registers of the single-line bus master.
module owm_cfg_regs
    import owm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data,
    output owm_cfg_t             cfg
);

    owm_cfg_t cfg_reg;
    owm_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                REG_RESET_LOW:     cfg_next.reset_low_us      = wr_data;
                REG_PRESENCE_WAIT: cfg_next.presence_wait_us  = wr_data;
                REG_RESET_TAIL:    cfg_next.reset_tail_us     = wr_data;
                REG_WRITE_ONE_LOW: cfg_next.write_one_low_us  = wr_data;
                REG_WRITE_ZERO:    cfg_next.write_zero_low_us = wr_data;
                REG_WRITE_SLOT:    cfg_next.write_slot_us     = wr_data;
                REG_READ_LOW:      cfg_next.read_low_us       = wr_data;
                REG_READ_SLOT:     cfg_next.read_slot_us      = wr_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_low_us      <= RESET_LOW_DEF;
            cfg_reg.presence_wait_us  <= PRESENCE_WAIT_DEF;
            cfg_reg.reset_tail_us     <= RESET_TAIL_DEF;
            cfg_reg.write_one_low_us  <= WRITE_ONE_LOW_DEF;
            cfg_reg.write_zero_low_us <= WRITE_ZERO_DEF;
            cfg_reg.write_slot_us     <= WRITE_SLOT_DEF;
            cfg_reg.read_low_us       <= READ_LOW_DEF;
            cfg_reg.read_slot_us      <= READ_SLOT_DEF;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/owm_seq.sv
// Bus sequencer: phase state, tick timer, bit shifter and one-tick next-state logic.
module owm_seq
    import owm_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  owm_item_t   item,
    input  owm_cfg_t    cfg,
    output owm_result_t res
);

    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_RST_LOW    = 3'd1;
    localparam logic [2:0] PH_RST_WAIT   = 3'd2;
    localparam logic [2:0] PH_RST_SAMPLE = 3'd3;
    localparam logic [2:0] PH_RST_TAIL   = 3'd4;
    localparam logic [2:0] PH_SLOT_LOW   = 3'd5;
    localparam logic [2:0] PH_SLOT_REST  = 3'd6;

    localparam logic [TIMER_BITS-1:0] LEN_ZERO = '0;
    localparam logic [TIMER_BITS-1:0] LEN_ONE  = TIMER_BITS'(1);

    logic [2:0]            phase_reg, phase_next;
    logic [TIMER_BITS-1:0] tick_reg, tick_next;
    logic [2:0]            bit_reg, bit_next;
    logic [7:0]            shift_reg, shift_next;
    logic                  presence_reg, presence_next;
    logic [1:0]            op_reg, op_next;
    logic [7:0]            rdbyte_reg, rdbyte_next;

    // Lengths count modulo the timer width.
    function automatic logic [TIMER_BITS-1:0] to_len(input logic [CFG_W-1:0] v);
        return TIMER_BITS'(v);
    endfunction

    function automatic logic [TIMER_BITS-1:0] slot_low_len(
        input owm_cfg_t   c,
        input logic [1:0] op,
        input logic [7:0] sb,
        input logic [2:0] bi
    );
        logic [TIMER_BITS-1:0] len;
        if (op == CMD_READ) begin
            len = to_len(c.read_low_us);
        end else if (sb[bi]) begin
            len = to_len(c.write_one_low_us);
        end else begin
            len = to_len(c.write_zero_low_us);
        end
        return len;
    endfunction

    // The released part of a slot lasts at least one tick.
    function automatic logic [TIMER_BITS-1:0] slot_rest_len(
        input owm_cfg_t   c,
        input logic [1:0] op,
        input logic [7:0] sb,
        input logic [2:0] bi
    );
        logic [TIMER_BITS-1:0] total;
        logic [TIMER_BITS-1:0] low;
        total = (op == CMD_READ) ? to_len(c.read_slot_us) : to_len(c.write_slot_us);
        low   = slot_low_len(c, op, sb, bi);
        return (total > low) ? (total - low) : LEN_ONE;
    endfunction

    always_comb begin
        logic [TIMER_BITS-1:0] cur_len;
        logic [TIMER_BITS-1:0] tick_inc;
        logic                  drive;
        logic                  busy;
        logic                  done;

        phase_next    = phase_reg;
        tick_next     = tick_reg;
        bit_next      = bit_reg;
        shift_next    = shift_reg;
        presence_next = presence_reg;
        op_next       = op_reg;
        rdbyte_next   = rdbyte_reg;
        drive         = 1'b0;
        busy          = 1'b0;
        done          = 1'b0;
        cur_len       = LEN_ZERO;
        tick_inc      = LEN_ZERO;

        // A command in idle starts on this same tick; empty opening phases are skipped.
        if (phase_reg == PH_IDLE && item.cmd != CMD_TICK) begin
            op_next    = item.cmd;
            bit_next   = 3'd0;
            tick_next  = LEN_ZERO;
            shift_next = (item.cmd == CMD_WRITE) ? item.write_byte : 8'd0;
            if (item.cmd == CMD_RESET) begin
                if (to_len(cfg.reset_low_us) != LEN_ZERO) begin
                    phase_next = PH_RST_LOW;
                end else if (to_len(cfg.presence_wait_us) != LEN_ZERO) begin
                    phase_next = PH_RST_WAIT;
                end else begin
                    phase_next = PH_RST_SAMPLE;
                end
            end else if (slot_low_len(cfg, item.cmd, shift_next, 3'd0) != LEN_ZERO) begin
                phase_next = PH_SLOT_LOW;
            end else begin
                phase_next = PH_SLOT_REST;
            end
        end

        if (phase_next != PH_IDLE) begin
            unique case (phase_next)
                PH_RST_LOW:    cur_len = to_len(cfg.reset_low_us);
                PH_RST_WAIT:   cur_len = to_len(cfg.presence_wait_us);
                PH_RST_SAMPLE: cur_len = LEN_ONE;
                PH_RST_TAIL:   cur_len = to_len(cfg.reset_tail_us);
                PH_SLOT_LOW:   cur_len = slot_low_len(cfg, op_next, shift_next, bit_next);
                PH_SLOT_REST:  cur_len = slot_rest_len(cfg, op_next, shift_next, bit_next);
                default:       cur_len = LEN_ZERO;
            endcase

            busy  = 1'b1;
            drive = (phase_next == PH_RST_LOW) || (phase_next == PH_SLOT_LOW);
            if (phase_next == PH_RST_SAMPLE) begin
                presence_next = !item.line_level;
            end
            // Read bits are sampled on the first released tick of the slot.
            if (phase_next == PH_SLOT_REST && tick_next == LEN_ZERO && op_next == CMD_READ) begin
                shift_next[bit_next] = shift_next[bit_next] | item.line_level;
            end

            tick_inc = tick_next + LEN_ONE;
            if (tick_inc < cur_len) begin
                tick_next = tick_inc;
            end else begin
                tick_next = LEN_ZERO;
                unique case (phase_next)
                    PH_RST_LOW: begin
                        phase_next = (to_len(cfg.presence_wait_us) != LEN_ZERO) ?
                                     PH_RST_WAIT : PH_RST_SAMPLE;
                    end
                    PH_RST_WAIT: begin
                        phase_next = PH_RST_SAMPLE;
                    end
                    PH_RST_SAMPLE: begin
                        if (to_len(cfg.reset_tail_us) != LEN_ZERO) begin
                            phase_next = PH_RST_TAIL;
                        end else begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    end
                    PH_SLOT_LOW: begin
                        phase_next = PH_SLOT_REST;
                    end
                    PH_SLOT_REST: begin
                        if (bit_next == LAST_BIT) begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end else begin
                            bit_next   = bit_next + 3'd1;
                            phase_next = (slot_low_len(cfg, op_next, shift_next, bit_next)
                                          != LEN_ZERO) ? PH_SLOT_LOW : PH_SLOT_REST;
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                endcase
            end
            if (done && op_next == CMD_READ) begin
                rdbyte_next = shift_next;
            end
        end

        res.drive_low = drive;
        res.busy_res  = busy;
        res.done_res  = done;
        res.read_byte = rdbyte_next;
        res.presence  = presence_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            tick_reg     <= LEN_ZERO;
            bit_reg      <= 3'd0;
            shift_reg    <= 8'd0;
            presence_reg <= 1'b0;
            op_reg       <= CMD_TICK;
            rdbyte_reg   <= 8'd0;
        end else if (fire) begin
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            bit_reg      <= bit_next;
            shift_reg    <= shift_next;
            presence_reg <= presence_next;
            op_reg       <= op_next;
            rdbyte_reg   <= rdbyte_next;
        end
    end

`ifndef ASSERT_OFF
    a_done_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && res.done_res) |=> (phase_reg == PH_IDLE))
        else $error("sequencer not idle after an operation completed");

    a_drive_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && res.drive_low) |-> res.busy_res)
        else $error("line driven low outside an operation");

    a_plain_tick_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && phase_reg == PH_IDLE && item.cmd == CMD_TICK) |=>
        (phase_reg == PH_IDLE && $stable(rdbyte_reg) && $stable(presence_reg)))
        else $error("plain tick in idle changed the sequencer state");
`endif

endmodule

// File: rtl/core/one_wire_master.sv
// Top level of the single-line bus master: beat registers, configuration and sequencer.
//
// one_wire_master drives a single open-drain bus line in microsecond steps. Every input
// beat is one microsecond tick carrying a command (plain tick, bus reset, write byte,
// read byte), the byte to send and the sampled line level, and every input beat yields
// exactly one result beat with the line drive for that tick, busy, done, the last read
// byte and the presence flag. A command given while idle starts on that same tick;
// commands given while busy are ignored. The block sustains one beat per clock cycle
// while results are taken: the sequencer updates its phase, tick timer and bit shifter
// in a single pass of short logic between the input beat register and the result
// register, and the input register lets a new beat in while a finished result still
// waits on m_ready. The eight timing registers are written through the cfg channel,
// which is always ready; write them only while no beat is in flight. Timing lengths
// are counted modulo 2^TIMER_BITS, a phase of zero length is skipped, and each slot
// ends with at least one released tick.
module one_wire_master
    import owm_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_cmd,
    input  logic [7:0]           s_write_byte,
    input  logic                 s_line_level,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_drive_low,
    output logic                 m_busy_res,
    output logic                 m_done_res,
    output logic [7:0]           m_read_byte,
    output logic                 m_presence,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    owm_cfg_t    cfg;
    owm_item_t   in_item_reg;
    logic        in_valid_reg;
    owm_result_t seq_res;
    owm_result_t out_res_reg;
    logic        out_valid_reg;
    logic        fire;

    // The configuration port never stalls.
    assign cfg_ready = 1'b1;

    owm_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // A held input beat is processed when the result register is empty or being drained.
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.cmd        <= s_cmd;
            in_item_reg.write_byte <= s_write_byte;
            in_item_reg.line_level <= s_line_level;
        end
    end

    owm_seq #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (seq_res)
    );

    // Result register: loads on every processed beat, empties when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_res_reg <= seq_res;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_drive_low = out_res_reg.drive_low;
    assign m_busy_res  = out_res_reg.busy_res;
    assign m_done_res  = out_res_reg.done_res;
    assign m_read_byte = out_res_reg.read_byte;
    assign m_presence  = out_res_reg.presence;

`ifndef ASSERT_OFF
    a_fire_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !fire)
        else $error("beat processed while the result register was full");

    a_fire_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> out_valid_reg)
        else $error("processed beat did not reach the result register");

    a_input_held_until_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !fire) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("held input beat lost before processing");
`endif

endmodule

// File: tb/sv/one_wire_master_checker.sv
// Result checker for the single-line bus master: tick predictor, expected-result queue, compare.
module one_wire_master_checker
    import owm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [1:0]           s_cmd,
    input  logic [7:0]           s_write_byte,
    input  logic                 s_line_level,

    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic                 m_drive_low,
    input  logic                 m_busy_res,
    input  logic                 m_done_res,
    input  logic [7:0]           m_read_byte,
    input  logic                 m_presence,

    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    output int                   mismatches,
    output int                   awaiting,
    output logic                 seq_idle
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RST_LOW,
        ST_RST_WAIT,
        ST_RST_SAMPLE,
        ST_RST_TAIL,
        ST_SLOT_LOW,
        ST_SLOT_REST
    } seq_state_t;

    // The tick timer is as wide as a timing register with the default TIMER_BITS,
    // so lengths need no extra wrapping here.
    owm_cfg_t      timing;
    seq_state_t    state;
    logic [CFG_W-1:0] ticks;
    logic [2:0]    bit_no;
    logic [7:0]    shifter;
    logic          present_flag;
    logic [1:0]    op;
    logic [7:0]    last_read;
    owm_result_t   expected_q[$];
    int            errs;
    int            beats;

    initial begin
        errs       = 0;
        beats      = 0;
    end

    function automatic logic [CFG_W-1:0] slot_low_ticks();
        if (op == CMD_READ) begin
            return timing.read_low_us;
        end
        if (shifter[bit_no]) begin
            return timing.write_one_low_us;
        end
        return timing.write_zero_low_us;
    endfunction

    // Every slot ends with at least one released tick.
    function automatic logic [CFG_W-1:0] slot_rest_ticks();
        logic [CFG_W-1:0] total;
        logic [CFG_W-1:0] low;
        total = (op == CMD_READ) ? timing.read_slot_us : timing.write_slot_us;
        low   = slot_low_ticks();
        return (total > low) ? total - low : CFG_W'(1);
    endfunction

    function automatic logic [CFG_W-1:0] phase_ticks();
        case (state)
            ST_RST_LOW:    return timing.reset_low_us;
            ST_RST_WAIT:   return timing.presence_wait_us;
            ST_RST_SAMPLE: return CFG_W'(1);
            ST_RST_TAIL:   return timing.reset_tail_us;
            ST_SLOT_LOW:   return slot_low_ticks();
            ST_SLOT_REST:  return slot_rest_ticks();
            default:       return '0;
        endcase
    endfunction

    // Steps past every phase whose time is used up; zero-length phases fall through.
    // Returns 1 when the operation has just finished.
    function automatic bit skip_spent_phases();
        for (int g = 0; g < 16; g++) begin
            if (state == ST_IDLE) begin
                return 1'b0;
            end
            if (ticks < phase_ticks()) begin
                return 1'b0;
            end
            ticks = '0;
            case (state)
                ST_RST_LOW:    state = ST_RST_WAIT;
                ST_RST_WAIT:   state = ST_RST_SAMPLE;
                ST_RST_SAMPLE: state = ST_RST_TAIL;
                ST_SLOT_LOW:   state = ST_SLOT_REST;
                ST_SLOT_REST: begin
                    if (bit_no == LAST_BIT) begin
                        state = ST_IDLE;
                        return 1'b1;
                    end
                    bit_no = bit_no + 3'd1;
                    state  = ST_SLOT_LOW;
                end
                default: begin
                    state = ST_IDLE;
                    return 1'b1;
                end
            endcase
        end
        return 1'b0;
    endfunction

    function automatic owm_result_t tick_result(input logic [1:0] cmd,
                                                input logic [7:0] wbyte,
                                                input logic       line);
        owm_result_t r;
        r = '0;
        // A command only starts from idle, and its first tick is this one.
        if (state == ST_IDLE && cmd != CMD_TICK) begin
            op      = cmd;
            bit_no  = '0;
            ticks   = '0;
            shifter = (cmd == CMD_WRITE) ? wbyte : 8'h00;
            state   = (cmd == CMD_RESET) ? ST_RST_LOW : ST_SLOT_LOW;
            void'(skip_spent_phases());
        end
        if (state != ST_IDLE) begin
            r.busy_res  = 1'b1;
            r.drive_low = (state == ST_RST_LOW || state == ST_SLOT_LOW);
            if (state == ST_RST_SAMPLE) begin
                present_flag = !line;
            end
            if (state == ST_SLOT_REST && ticks == '0 && op == CMD_READ) begin
                shifter[bit_no] = shifter[bit_no] | line;
            end
            ticks = ticks + CFG_W'(1);
            if (skip_spent_phases()) begin
                r.done_res = 1'b1;
                if (op == CMD_READ) begin
                    last_read = shifter;
                end
            end
        end
        r.read_byte = last_read;
        r.presence  = present_flag;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        owm_result_t got;
        owm_result_t want;
        if (!aresetn) begin
            timing.reset_low_us      = RESET_LOW_DEF;
            timing.presence_wait_us  = PRESENCE_WAIT_DEF;
            timing.reset_tail_us     = RESET_TAIL_DEF;
            timing.write_one_low_us  = WRITE_ONE_LOW_DEF;
            timing.write_zero_low_us = WRITE_ZERO_DEF;
            timing.write_slot_us     = WRITE_SLOT_DEF;
            timing.read_low_us       = READ_LOW_DEF;
            timing.read_slot_us      = READ_SLOT_DEF;
            state        = ST_IDLE;
            ticks        = '0;
            bit_no       = '0;
            shifter      = '0;
            present_flag = 1'b0;
            op           = CMD_TICK;
            last_read    = '0;
            expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_RESET_LOW:     timing.reset_low_us      = cfg_data;
                    REG_PRESENCE_WAIT: timing.presence_wait_us  = cfg_data;
                    REG_RESET_TAIL:    timing.reset_tail_us     = cfg_data;
                    REG_WRITE_ONE_LOW: timing.write_one_low_us  = cfg_data;
                    REG_WRITE_ZERO:    timing.write_zero_low_us = cfg_data;
                    REG_WRITE_SLOT:    timing.write_slot_us     = cfg_data;
                    REG_READ_LOW:      timing.read_low_us       = cfg_data;
                    default:           timing.read_slot_us      = cfg_data;
                endcase
            end
            if (m_valid && m_ready) begin
                got.drive_low = m_drive_low;
                got.busy_res  = m_busy_res;
                got.done_res  = m_done_res;
                got.read_byte = m_read_byte;
                got.presence  = m_presence;
                if (expected_q.size() == 0) begin
                    errs++;
                    if (errs <= 10) begin
                        $display("%0t: result beat %0d arrived with nothing expected", $realtime,
                                 beats);
                    end
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        errs++;
                        if (errs <= 10) begin
                            $display("%0t: result beat %0d (expected / actual)", $realtime,
                                     beats);
                            $display("    drive %b/%b busy %b/%b done %b/%b read %h/%h pres %b/%b",
                                     want.drive_low, got.drive_low, want.busy_res, got.busy_res,
                                     want.done_res, got.done_res, want.read_byte, got.read_byte,
                                     want.presence, got.presence);
                        end
                    end
                end
                beats++;
            end
            if (s_valid && s_ready) begin
                expected_q.push_back(tick_result(s_cmd, s_write_byte, s_line_level));
            end
        end
        mismatches <= errs;
        awaiting   <= expected_q.size();
        seq_idle   <= (state == ST_IDLE);
    end

endmodule

// File: tb/sv/one_wire_master_tb.sv
// Top of the single-line bus master testbench: clock, reset, stimulus, stalls and verdict.
module one_wire_master_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import owm_pkg::*;

    // Nine timing settings are visited in turn: all zero (every optional phase skipped),
    // five random short settings, the power-on defaults, all registers at their maximum,
    // and one more random short setting.
    localparam int NUM_SETTINGS = 9;
    // Cycles without any beat on any channel before the run is declared hung.
    localparam int STALL_LIMIT  = 2000;
    // Idle cycles waited before the verdict, with margin over the input-to-result path.
    localparam int DRAIN_PAUSE  = 8;
    // Bus levels for the opening directed beats; bit i goes with beat i.
    localparam logic [26:0] OPENING_LINES = 27'h4B2_D36E;

    logic                 aclk;
    logic                 aresetn       = 1'b0;

    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_cmd         = CMD_TICK;
    logic [7:0]           s_write_byte  = 8'h00;
    logic                 s_line_level  = 1'b1;

    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic                 m_drive_low;
    logic                 m_busy_res;
    logic                 m_done_res;
    logic [7:0]           m_read_byte;
    logic                 m_presence;

    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = REG_RESET_LOW;
    logic [CFG_W-1:0]     cfg_data      = '0;

    // Checker outputs: failures so far, results still owed, and whether the predicted
    // sequencer sits idle after the latest input beat accepted.
    int                   mismatches;
    int                   awaiting;
    logic                 seq_idle;

    // Percent of cycles in which the sender holds back a beat and the receiver stalls.
    int                   send_idle_pct = 16;
    int                   recv_idle_pct = 68;

    one_wire_master u_dut (.*);

    one_wire_master_checker u_check (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // The receiver decides afresh every cycle whether to take a result beat.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offers one tick beat, after a random number of idle cycles, and returns on the
    // edge at which the block takes it. Valid is left high so that back-to-back beats
    // never lower and raise it in the same step.
    task automatic send_tick(input logic [1:0] cmd, input logic [7:0] wbyte,
                             input logic line);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_write_byte <= wbyte;
        s_line_level <= line;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Holds the input channel quiet until every result beat owed has been taken. The
    // first edge is always waited so that the checker has seen the last input beat.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (awaiting != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    initial begin : stimulus
        owm_cfg_t   plan;
        logic [1:0] cmd;
        logic [7:0] wbyte;
        int         roll;
        int         count;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
            // Stall profile: sender light and receiver heavy first, then swapped, and
            // in the last third neither side holds back.
            if (ph < 3) begin
                send_idle_pct = 16;
                recv_idle_pct <= 68;
            end else if (ph < 6) begin
                send_idle_pct = 68;
                recv_idle_pct <= 16;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end

            // Pick the timing for this stretch. Short random lengths keep operations
            // brief and often put a slot's low time at or past its total.
            case (ph)
                0: plan = '0;
                6: begin
                    plan.reset_low_us      = RESET_LOW_DEF;
                    plan.presence_wait_us  = PRESENCE_WAIT_DEF;
                    plan.reset_tail_us     = RESET_TAIL_DEF;
                    plan.write_one_low_us  = WRITE_ONE_LOW_DEF;
                    plan.write_zero_low_us = WRITE_ZERO_DEF;
                    plan.write_slot_us     = WRITE_SLOT_DEF;
                    plan.read_low_us       = READ_LOW_DEF;
                    plan.read_slot_us      = READ_SLOT_DEF;
                end
                7: plan = '1;
                default: begin
                    plan.reset_low_us      = CFG_W'($urandom_range(12));
                    plan.presence_wait_us  = CFG_W'($urandom_range(12));
                    plan.reset_tail_us     = CFG_W'($urandom_range(12));
                    plan.write_one_low_us  = CFG_W'($urandom_range(12));
                    plan.write_zero_low_us = CFG_W'($urandom_range(12));
                    plan.write_slot_us     = CFG_W'($urandom_range(12));
                    plan.read_low_us       = CFG_W'($urandom_range(12));
                    plan.read_slot_us      = CFG_W'($urandom_range(12));
                end
            endcase

            // No result is owed here, so the registers can be rewritten safely. After
            // the long-timing stretches an operation may still be running; it simply
            // carries on under the new lengths.
            write_reg(REG_RESET_LOW,     plan.reset_low_us);
            write_reg(REG_PRESENCE_WAIT, plan.presence_wait_us);
            write_reg(REG_RESET_TAIL,    plan.reset_tail_us);
            write_reg(REG_WRITE_ONE_LOW, plan.write_one_low_us);
            write_reg(REG_WRITE_ZERO,    plan.write_zero_low_us);
            write_reg(REG_WRITE_SLOT,    plan.write_slot_us);
            write_reg(REG_READ_LOW,      plan.read_low_us);
            write_reg(REG_READ_SLOT,     plan.read_slot_us);
            cfg_valid <= 1'b0;

            // Opening directed beats under all-zero timing, where a bus reset is just
            // its sample tick and each slot is one released tick. They cover a reset
            // that sees a device and one that does not, a write of all ones and of all
            // zeros, a read of a fixed pattern, and reset and read commands that arrive
            // mid-operation and must be dropped.
            if (ph == 0) begin
                for (int i = 0; i < 27; i++) begin
                    case (i)
                        0, 1, 4: cmd = CMD_RESET;
                        3, 19:   cmd = CMD_WRITE;
                        5, 11:   cmd = CMD_READ;
                        default: cmd = CMD_TICK;
                    endcase
                    if (i == 3) begin
                        wbyte = 8'hFF;
                    end else if (i == 19) begin
                        wbyte = 8'h00;
                    end else begin
                        wbyte = i[0] ? 8'hFF : 8'h00;
                    end
                    send_tick(cmd, wbyte, OPENING_LINES[i]);
                end
            end

            case (ph)
                0:       count = 120;
                6:       count = 200;
                7:       count = 100;
                default: count = 220;
            endcase

            // Random ticks: mostly plain ticks, so that operations run to completion,
            // with commands sprinkled in. Commands that land on a busy sequencer check
            // that they are dropped along with their byte.
            for (int i = 0; i < count; i++) begin
                roll = $urandom_range(99);
                if (roll < 70) begin
                    cmd = CMD_TICK;
                end else if (roll < 80) begin
                    cmd = CMD_RESET;
                end else if (roll < 90) begin
                    cmd = CMD_WRITE;
                end else begin
                    cmd = CMD_READ;
                end
                case ($urandom_range(7))
                    0:       wbyte = 8'h00;
                    1:       wbyte = 8'hFF;
                    default: wbyte = 8'($urandom);
                endcase
                // Halfway through, the sender waits for the result queue to empty.
                if (i == count / 2) begin
                    drain_results();
                end
                send_tick(cmd, wbyte, 1'($urandom_range(1)));
            end

            // Let the operation in flight run out with plain ticks, then wait for the
            // last result. Under the default and maximum timing an operation can outlast
            // the beats of its stretch, so those stretches hand it on to the next setting.
            drain_results();
            if (ph != 6 && ph != 7) begin
                while (!seq_idle) begin
                    send_tick(CMD_TICK, 8'($urandom), 1'($urandom_range(1)));
                end
                drain_results();
            end
        end

        repeat (DRAIN_PAUSE) @(posedge aclk);
        if (mismatches == 0 && awaiting == 0) begin
            $display("one_wire_master_tb: done, clean");
        end else begin
            $display("one_wire_master_tb: done, errors");
        end
        $finish;
    end

    // Hang guard: any beat on any channel restarts the count.
    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                    || (cfg_valid && cfg_ready)) begin
                stuck = 0;
            end else begin
                stuck++;
            end
        end
        $display("one_wire_master_tb: done, errors");
        $finish;
    end

endmodule

// File: files.f
rtl/core/owm_pkg.sv
rtl/core/owm_cfg_regs.sv
rtl/core/owm_seq.sv
rtl/core/one_wire_master.sv
tb/sv/one_wire_master_checker.sv
tb/sv/one_wire_master_tb.sv
